@@ rtl/mkcw_pkg.sv @@
package mkcw_pkg;

    // Fixed field widths of the token and result items
    localparam int KEY_W   = 4;
    localparam int KEY_N   = 16;
    localparam int KWC_W   = 5;
    localparam int POS_O_W = 16;
    localparam int LEN_O_W = 17;

    // Register map: word index taken from paddr[2]
    localparam int  PADDR_W           = 3;
    localparam logic REG_KEYWORD_COUNT = 1'b0;

    // "No window yet" length mark
    localparam logic [LEN_O_W-1:0] LEN_NONE = 17'h1FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FPOP,
        ST_PUSH,
        ST_RD,
        ST_CHK,
        ST_DONE
    } st_t;

    typedef enum logic [1:0] {
        CNT_NOP,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    typedef struct packed {
        cnt_op_t          op;
        logic [KEY_W-1:0] key;
    } cnt_cmd_t;

endpackage

@@ rtl/mkcw_ram.sv @@
module mkcw_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/mkcw_cnt.sv @@
module mkcw_cnt import mkcw_pkg::*; #(
    parameter int MAX_KEYWORDS = 16,
    parameter int CNT_W        = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cnt_cmd_t         cmd,
    output logic [CNT_W-1:0] rd_val
);

    // Only keys 0..15 can occur, so the table never needs more slots
    localparam int NKEY  = (MAX_KEYWORDS < KEY_N) ? MAX_KEYWORDS : KEY_N;
    localparam int IDX_W = (NKEY > 1) ? $clog2(NKEY) : 1;
    localparam int NSLOT = 1 << IDX_W;

    logic [CNT_W-1:0] cnt_reg [NSLOT];
    logic [IDX_W-1:0] idx;

    assign idx    = cmd.key[IDX_W-1:0];
    assign rd_val = cnt_reg[idx];

    // Single increment/decrement unit on one selected counter; clear resets all counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSLOT; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            case (cmd.op)
                CNT_INC: begin
                    cnt_reg[idx] <= rd_val + CNT_W'(1);
                end
                CNT_DEC: begin
                    if (rd_val != '0) begin
                        cnt_reg[idx] <= rd_val - CNT_W'(1);
                    end
                end
                CNT_CLR: begin
                    for (int i = 0; i < NSLOT; i++) begin
                        cnt_reg[i] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ rtl/minimum_keyword_cover_window.sv @@
// Minimum keyword cover window. Each accepted item is one token, already
// classed as keyword key_id or as no keyword. The block tracks the shortest
// span of tokens that holds every keyword 0..keyword_count-1 (the earliest
// on ties) and, on the token flagged end_of_text, emits one result item with
// found, first_pos, last_pos, window_len and overflowed, then starts a new
// text. A plain token is handled in ST_IDLE. A keyword token passes ST_PUSH,
// ST_RD and ST_CHK, with ST_CHK repeated for each position dropped from the
// front of the window, and ST_FPOP first when the position FIFO is full; the
// end-of-text token adds ST_DONE to load the result. These steps come from the
// single read port of the position FIFO RAM (registered read) and the one
// counter update unit, which handles one keyword count per cycle. s_ready is
// low outside ST_IDLE. Keyword positions are never reused, so each is dropped at most once.
module minimum_keyword_cover_window import mkcw_pkg::*; #(
    parameter int MAX_KEYWORDS = 16,
    parameter int MAX_TOKENS   = 65536,
    parameter int FIFO_DEPTH   = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Token channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_is_keyword,
    input  logic [KEY_W-1:0]    s_key_id,
    input  logic                s_end_of_text,
    // Result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found,
    output logic [POS_O_W-1:0]  m_first_pos,
    output logic [POS_O_W-1:0]  m_last_pos,
    output logic [LEN_O_W-1:0]  m_window_len,
    output logic                m_overflowed,
    // Configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FW    = $clog2(FIFO_DEPTH + 1);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int POS_W = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int TOK_W = $clog2(MAX_TOKENS + 1);
    localparam int LEN_W = (TOK_W > LEN_O_W) ? TOK_W : LEN_O_W;
    localparam int ENT_W = POS_W + KEY_W;

    localparam logic [LEN_W-1:0] BEST_NONE = LEN_W'(LEN_NONE);

    st_t                state_reg, state_next;
    logic [KWC_W-1:0]   kc_reg, kc_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [KWC_W-1:0]   cov_reg, cov_next;
    logic [TOK_W-1:0]   tok_pos_reg, tok_pos_next;
    logic [LEN_W-1:0]   best_len_reg, best_len_next;
    logic [POS_W-1:0]   best_start_reg, best_start_next;
    logic [POS_W-1:0]   best_end_reg, best_end_next;
    logic               ovf_reg, ovf_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               eot_reg, eot_next;
    logic [POS_W-1:0]   cur_pos_reg, cur_pos_next;

    logic               m_valid_reg, m_valid_next;
    logic               found_reg, found_next;
    logic [POS_O_W-1:0] first_reg, first_next;
    logic [POS_O_W-1:0] last_reg, last_next;
    logic [LEN_O_W-1:0] wlen_reg, wlen_next;
    logic               ovf_out_reg, ovf_out_next;

    logic [KWC_W-1:0]   eff;
    logic               s_fire;
    logic               fifo_full;
    logic [AW-1:0]      head_inc;
    logic [AW:0]        wsum;
    logic [AW:0]        wslot;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [ENT_W-1:0]   ram_wdata;
    logic [ENT_W-1:0]   ram_rdata;
    logic [POS_W-1:0]   front_pos;
    logic [KEY_W-1:0]   front_key;
    cnt_cmd_t           cnt_cmd;
    logic [CNT_W-1:0]   cnt_val;
    logic [LEN_W-1:0]   cand_len;
    logic               chk_pop;
    logic               best_found;
    logic [POS_W+POS_O_W-1:0] bs_ext;
    logic [POS_W+POS_O_W-1:0] be_ext;
    logic [LEN_W+LEN_O_W-1:0] bl_ext;

    // Effective keyword count: 0 acts as 1, clamp to MAX_KEYWORDS
    always_comb begin
        if (kc_reg == '0) begin
            eff = KWC_W'(1);
        end else if (int'(kc_reg) > MAX_KEYWORDS) begin
            eff = KWC_W'(MAX_KEYWORDS);
        end else begin
            eff = kc_reg;
        end
    end

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_KEYWORD_COUNT) ? {{(32 - KWC_W){1'b0}}, kc_reg} : '0;

    always_comb begin
        kc_next = kc_reg;
        if (psel && penable && pwrite && paddr[2] == REG_KEYWORD_COUNT) begin
            kc_next = pwdata[KWC_W-1:0];
        end
    end

    // FIFO addressing
    assign fifo_full = (fill_reg == FW'(FIFO_DEPTH));
    assign head_inc  = (head_reg == AW'(FIFO_DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign wsum      = {1'b0, head_reg} + (AW + 1)'(fill_reg);
    assign wslot     = (wsum >= (AW + 1)'(FIFO_DEPTH)) ? wsum - (AW + 1)'(FIFO_DEPTH) : wsum;
    assign ram_wdata = {cur_pos_reg, key_reg};
    assign front_pos = ram_rdata[ENT_W-1:KEY_W];
    assign front_key = ram_rdata[KEY_W-1:0];

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign chk_pop  = (state_reg == ST_CHK) && (cnt_val > CNT_W'(1));
    assign cand_len = LEN_W'(cur_pos_reg) - LEN_W'(front_pos) + LEN_W'(1);

    // Result formatting
    assign best_found = (best_len_reg != BEST_NONE);
    assign bs_ext     = {{POS_O_W{1'b0}}, best_start_reg};
    assign be_ext     = {{POS_O_W{1'b0}}, best_end_reg};
    assign bl_ext     = {{LEN_O_W{1'b0}}, best_len_reg};

    // Sequencer: next state, counter commands, FIFO, best-window and result updates
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        cov_next        = cov_reg;
        tok_pos_next    = tok_pos_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        best_end_next   = best_end_reg;
        ovf_next        = ovf_reg;
        key_next        = key_reg;
        eot_next        = eot_reg;
        cur_pos_next    = cur_pos_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        found_next      = found_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        wlen_next       = wlen_reg;
        ovf_out_next    = ovf_out_reg;
        cnt_cmd.op      = CNT_NOP;
        cnt_cmd.key     = key_reg;
        ram_we          = 1'b0;
        ram_raddr       = head_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    key_next     = s_key_id;
                    eot_next     = s_end_of_text;
                    cur_pos_next = tok_pos_reg[POS_W-1:0];
                    if (tok_pos_reg >= TOK_W'(MAX_TOKENS)) begin
                        // Text too long: token only flags overflow, or ends the text
                        ovf_next = 1'b1;
                        if (s_end_of_text) begin
                            state_next = ST_DONE;
                        end
                    end else begin
                        tok_pos_next = tok_pos_reg + TOK_W'(1);
                        if (s_is_keyword && ({1'b0, s_key_id} < eff)) begin
                            if (fifo_full) begin
                                // Front is read now, dropped next cycle
                                ovf_next   = 1'b1;
                                state_next = ST_FPOP;
                            end else begin
                                state_next = ST_PUSH;
                            end
                        end else if (s_end_of_text) begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_FPOP: begin
                cnt_cmd.op  = CNT_DEC;
                cnt_cmd.key = front_key;
                if (cnt_val == CNT_W'(1) && cov_reg != '0) begin
                    cov_next = cov_reg - KWC_W'(1);
                end
                head_next  = head_inc;
                fill_next  = fill_reg - FW'(1);
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                cnt_cmd.op = CNT_INC;
                if (cnt_val == '0) begin
                    cov_next = cov_reg + KWC_W'(1);
                end
                ram_we     = 1'b1;
                fill_next  = fill_reg + FW'(1);
                state_next = ST_RD;
            end
            ST_RD: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                cnt_cmd.key = front_key;
                if (chk_pop) begin
                    // Front keyword occurs again later: drop it, read next front
                    cnt_cmd.op = CNT_DEC;
                    head_next  = head_inc;
                    fill_next  = fill_reg - FW'(1);
                    ram_raddr  = head_inc;
                end else begin
                    if (cov_reg >= eff && cand_len < best_len_reg) begin
                        best_len_next   = cand_len;
                        best_start_next = front_pos;
                        best_end_next   = cur_pos_reg;
                    end
                    state_next = eot_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                // Load the result once the output register is free, then clear
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    found_next      = best_found;
                    first_next      = best_found ? bs_ext[POS_O_W-1:0] : '0;
                    last_next       = best_found ? be_ext[POS_O_W-1:0] : '0;
                    wlen_next       = best_found ? bl_ext[LEN_O_W-1:0] : '0;
                    ovf_out_next    = ovf_reg;
                    cnt_cmd.op      = CNT_CLR;
                    head_next       = '0;
                    fill_next       = '0;
                    cov_next        = '0;
                    tok_pos_next    = '0;
                    best_len_next   = BEST_NONE;
                    best_start_next = '0;
                    best_end_next   = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            kc_reg         <= KWC_W'(1);
            head_reg       <= '0;
            fill_reg       <= '0;
            cov_reg        <= '0;
            tok_pos_reg    <= '0;
            best_len_reg   <= BEST_NONE;
            best_start_reg <= '0;
            best_end_reg   <= '0;
            ovf_reg        <= 1'b0;
            eot_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            kc_reg         <= kc_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            cov_reg        <= cov_next;
            tok_pos_reg    <= tok_pos_next;
            best_len_reg   <= best_len_next;
            best_start_reg <= best_start_next;
            best_end_reg   <= best_end_next;
            ovf_reg        <= ovf_next;
            eot_reg        <= eot_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        cur_pos_reg <= cur_pos_next;
        found_reg   <= found_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        wlen_reg    <= wlen_next;
        ovf_out_reg <= ovf_out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_found      = found_reg;
    assign m_first_pos  = first_reg;
    assign m_last_pos   = last_reg;
    assign m_window_len = wlen_reg;
    assign m_overflowed = ovf_out_reg;

    // Keyword position FIFO storage
    mkcw_ram #(
        .WIDTH (ENT_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wslot[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Per-keyword occurrence counters
    mkcw_cnt #(
        .MAX_KEYWORDS (MAX_KEYWORDS),
        .CNT_W        (CNT_W)
    ) u_cnt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cnt_cmd),
        .rd_val  (cnt_val)
    );

    // Checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(FIFO_DEPTH))
        else $error("position FIFO fill beyond depth");

    a_front_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CHK |-> (cnt_val != '0 && fill_reg != '0))
        else $error("front entry has no matching keyword count");

    a_done_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("end of text did not produce a result");

    a_found_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && found_reg) |-> wlen_reg != '0)
        else $error("found result with zero window length");

endmodule
